// ===== sv/crc16_frame_deframer_defines.svh =====
// Assertion macros for the frame deframer.
`ifndef CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
// Check a property while out of reset.
`define C16FD_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("c16fd check failed");
// Check a property at every edge, reset included.
`define C16FD_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("c16fd check failed");
`else
`define C16FD_ASSERT(lbl, prop)
`define C16FD_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== sv/c16fd_pkg.sv =====
package c16fd_pkg;

   // Default payload buffer depth
   localparam int DEF_PAYLOAD_DEPTH = 64;

   // CRC-16-CCITT
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Fixed field widths
   localparam int LEN_W = 7;
   localparam int IDX_W = 6;
   localparam logic [LEN_W-1:0] LEN_SAT = 7'd127;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_LEN_BIG  = 2'd1,
      ST_BAD_TAIL = 2'd2,
      ST_BAD_CRC  = 2'd3
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_SYNC_FIRST  = 2'd0,
      REG_SYNC_SECOND = 2'd1,
      REG_TAIL_VALUE  = 2'd2,
      REG_MAX_PAYLOAD = 2'd3
   } reg_index_type;

   // Receiver phases
   typedef enum logic [3:0] {
      PH_SYNC0   = 4'd0,
      PH_SYNC1   = 4'd1,
      PH_LEN     = 4'd2,
      PH_SEQ     = 4'd3,
      PH_ID      = 4'd4,
      PH_PAY     = 4'd5,
      PH_CRCLO   = 4'd6,
      PH_CRCHI   = 4'd7,
      PH_TAIL    = 4'd8,
      PH_EMIT_RD = 4'd9,
      PH_EMIT_LD = 4'd10
   } phase_type;

   // Fold one byte into the CRC, MSB first
   function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/crc16_frame_deframer.sv =====
// Frame deframer: sync, length, seq, id, payload, CRC-16 (low byte first), tail.
// Header, payload and trailer bytes: one byte per cycle outside the emit phases while the result register is free.
// Good frame: one result per payload byte, read from the payload memory.
// Error or empty frame: one result, loaded on the tail or length byte.
// Synchronous active-high reset: hunting first sync byte, no result pending, regs to defaults.
`include "crc16_frame_deframer_defines.svh"

module crc16_frame_deframer #(
   parameter int PAYLOAD_DEPTH = c16fd_pkg::DEF_PAYLOAD_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [1:0]                     rsp_status,
   output logic [c16fd_pkg::LEN_W-1:0]    rsp_frame_length,
   output logic [7:0]                     rsp_sequence_res,
   output logic [7:0]                     rsp_message_id,
   output logic                           rsp_has_payload,
   output logic [7:0]                     rsp_payload_byte,
   output logic [c16fd_pkg::IDX_W-1:0]    rsp_byte_index,
   output logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [1:0]                     csr_index,
   input  logic [7:0]                     csr_wdata
);
   import c16fd_pkg::*;

   localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
   localparam logic [7:0] DEPTH_LIM = 8'(PAYLOAD_DEPTH);

   // Configuration registers
   logic [7:0]       sync_first_ff, sync_second_ff, tail_value_ff;
   logic [LEN_W-1:0] max_payload_ff;

   // Frame state
   phase_type        phase_ff, phase_in;
   logic [LEN_W-1:0] held_length_ff;
   logic [7:0]       held_sequence_ff, held_message_id_ff;
   logic [15:0]      running_crc_ff;
   logic [7:0]       received_crc_low_ff;
   logic [LEN_W-1:0] payload_count_ff;
   logic             crc_bad_ff;
   logic [IDX_W-1:0] rd_idx_ff;

   // Payload memory
   logic [7:0]       pay_mem [PAYLOAD_DEPTH];
   logic [7:0]       mem_rdata_ff;

   // Result register
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   logic [LEN_W-1:0] rsp_frame_length_ff;
   logic [7:0]       rsp_sequence_ff, rsp_message_id_ff, rsp_payload_ff;
   logic             rsp_has_payload_ff, rsp_last_ff;
   logic [IDX_W-1:0] rsp_byte_index_ff;

   // Control
   logic             slot_free, accept, input_phase;
   logic             len_bad, tail_bad, emit_last;
   logic             mem_we, mem_re;
   logic             rsp_load;
   status_type       rsp_status_in;
   logic [LEN_W-1:0] rsp_frame_length_in;
   logic [7:0]       rsp_sequence_in, rsp_message_id_in, rsp_payload_in;
   logic             rsp_has_payload_in, rsp_last_in;
   logic [IDX_W-1:0] rsp_byte_index_in;
   logic [15:0]      crc_next;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign input_phase = (phase_ff != PH_EMIT_RD) && (phase_ff != PH_EMIT_LD);
   assign accept      = req_valid && req_ready;
   assign len_bad     = (req_rx_byte > {1'b0, max_payload_ff}) || (req_rx_byte > DEPTH_LIM);
   assign tail_bad    = req_rx_byte != tail_value_ff;
   assign emit_last   = (LEN_W'(rd_idx_ff) + 7'd1) == held_length_ff;
   assign crc_next    = crc16_step(running_crc_ff, req_rx_byte);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SYNC0: begin
            if (accept && req_rx_byte == sync_first_ff) phase_in = PH_SYNC1;
         end
         PH_SYNC1: begin
            if (accept) begin
               if (req_rx_byte == sync_second_ff) begin
                  phase_in = PH_LEN;
               end else if (req_rx_byte != sync_first_ff) begin
                  phase_in = PH_SYNC0;
               end
            end
         end
         PH_LEN: begin
            if (accept) phase_in = len_bad ? PH_SYNC0 : PH_SEQ;
         end
         PH_SEQ: begin
            if (accept) phase_in = PH_ID;
         end
         PH_ID: begin
            if (accept) phase_in = (held_length_ff == '0) ? PH_CRCLO : PH_PAY;
         end
         PH_PAY: begin
            if (accept && ((payload_count_ff + 7'd1) >= held_length_ff)) phase_in = PH_CRCLO;
         end
         PH_CRCLO: begin
            if (accept) phase_in = PH_CRCHI;
         end
         PH_CRCHI: begin
            if (accept) phase_in = PH_TAIL;
         end
         PH_TAIL: begin
            if (accept) begin
               phase_in = (!tail_bad && !crc_bad_ff && held_length_ff != '0) ?
                          PH_EMIT_RD : PH_SYNC0;
            end
         end
         PH_EMIT_RD: begin
            if (slot_free) phase_in = PH_EMIT_LD;
         end
         PH_EMIT_LD: begin
            phase_in = emit_last ? PH_SYNC0 : PH_EMIT_RD;
         end
         default: phase_in = PH_SYNC0;
      endcase
   end

   // Handshake, memory strobes and result contents
   always_comb begin
      req_ready           = input_phase && slot_free;
      mem_we              = 1'b0;
      mem_re              = 1'b0;
      rsp_load            = 1'b0;
      rsp_status_in       = ST_OK;
      rsp_frame_length_in = held_length_ff;
      rsp_sequence_in     = held_sequence_ff;
      rsp_message_id_in   = held_message_id_ff;
      rsp_has_payload_in  = 1'b0;
      rsp_payload_in      = 8'h00;
      rsp_byte_index_in   = '0;
      rsp_last_in         = 1'b1;
      unique case (phase_ff)
         PH_LEN: begin
            rsp_load            = accept && len_bad;
            rsp_status_in       = ST_LEN_BIG;
            rsp_frame_length_in = req_rx_byte[7] ? LEN_SAT : req_rx_byte[LEN_W-1:0];
            rsp_sequence_in     = 8'h00;
            rsp_message_id_in   = 8'h00;
         end
         PH_PAY: begin
            mem_we = accept;
         end
         PH_TAIL: begin
            rsp_load = accept && (tail_bad || crc_bad_ff || held_length_ff == '0);
            if (tail_bad) begin
               rsp_status_in = ST_BAD_TAIL;
            end else if (crc_bad_ff) begin
               rsp_status_in = ST_BAD_CRC;
            end else begin
               rsp_status_in = ST_OK;
            end
         end
         PH_EMIT_RD: begin
            mem_re = slot_free;
         end
         PH_EMIT_LD: begin
            rsp_load           = 1'b1;
            rsp_has_payload_in = 1'b1;
            rsp_payload_in     = mem_rdata_ff;
            rsp_byte_index_in  = rd_idx_ff;
            rsp_last_in        = emit_last;
         end
         default: begin
         end
      endcase
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= 8'hAA;
         sync_second_ff <= 8'h55;
         tail_value_ff  <= 8'h0D;
         max_payload_ff <= 7'd64;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_SYNC_FIRST:  sync_first_ff  <= csr_wdata;
            REG_SYNC_SECOND: sync_second_ff <= csr_wdata;
            REG_TAIL_VALUE:  tail_value_ff  <= csr_wdata;
            REG_MAX_PAYLOAD: max_payload_ff <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_SYNC0;
         rsp_valid_ff     <= 1'b0;
         held_length_ff   <= '0;
         payload_count_ff <= '0;
         crc_bad_ff       <= 1'b0;
         rd_idx_ff        <= '0;
         running_crc_ff   <= CRC_INIT;
      end else begin
         phase_ff <= phase_in;
         // hold result until taken, load when slot frees
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept) begin
            unique case (phase_ff)
               PH_SYNC1: begin
                  running_crc_ff   <= CRC_INIT;
                  payload_count_ff <= '0;
                  crc_bad_ff       <= 1'b0;
               end
               PH_LEN: begin
                  held_length_ff <= req_rx_byte[LEN_W-1:0];
                  running_crc_ff <= crc_next;
               end
               PH_SEQ, PH_ID: begin
                  running_crc_ff <= crc_next;
               end
               PH_PAY: begin
                  running_crc_ff   <= crc_next;
                  payload_count_ff <= payload_count_ff + 7'd1;
               end
               PH_CRCHI: begin
                  crc_bad_ff <= {req_rx_byte, received_crc_low_ff} != running_crc_ff;
               end
               PH_TAIL: begin
                  rd_idx_ff <= '0;
               end
               default: begin
               end
            endcase
         end
         // advance read pointer after each payload result
         if (phase_ff == PH_EMIT_LD) rd_idx_ff <= rd_idx_ff + 6'd1;
      end
   end

   // Header bytes and received CRC low byte
   always_ff @(posedge clock) begin
      if (accept && phase_ff == PH_SEQ)   held_sequence_ff    <= req_rx_byte;
      if (accept && phase_ff == PH_ID)    held_message_id_ff  <= req_rx_byte;
      if (accept && phase_ff == PH_CRCLO) received_crc_low_ff <= req_rx_byte;
   end

   // Payload memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) pay_mem[payload_count_ff[AW-1:0]] <= req_rx_byte;
      if (mem_re) mem_rdata_ff <= pay_mem[rd_idx_ff[AW-1:0]];
   end

   // Result register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff       <= rsp_status_in;
         rsp_frame_length_ff <= rsp_frame_length_in;
         rsp_sequence_ff     <= rsp_sequence_in;
         rsp_message_id_ff   <= rsp_message_id_in;
         rsp_has_payload_ff  <= rsp_has_payload_in;
         rsp_payload_ff      <= rsp_payload_in;
         rsp_byte_index_ff   <= rsp_byte_index_in;
         rsp_last_ff         <= rsp_last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_frame_length = rsp_frame_length_ff;
   assign rsp_sequence_res = rsp_sequence_ff;
   assign rsp_message_id   = rsp_message_id_ff;
   assign rsp_has_payload  = rsp_has_payload_ff;
   assign rsp_payload_byte = rsp_payload_ff;
   assign rsp_byte_index   = rsp_byte_index_ff;
   assign rsp_last         = rsp_last_ff;

   // Checks
   `C16FD_ASSERT(a_load_free, rsp_load |-> (!rsp_valid_ff || rsp_ready))
   `C16FD_ASSERT(a_emit_shows, phase_ff == PH_EMIT_LD |=> rsp_valid_ff)
   `C16FD_ASSERT(a_pay_count, phase_ff == PH_PAY |-> payload_count_ff < held_length_ff)
   `C16FD_ASSERT(a_idx_in_frame, (rsp_valid_ff && rsp_has_payload_ff) |-> (LEN_W'(rsp_byte_index_ff) < rsp_frame_length_ff))
   `C16FD_ASSERT_ALWAYS(a_reset_idle, reset |=> (!rsp_valid_ff && phase_ff == PH_SYNC0))

endmodule

// ===== verif/crc16_frame_deframer_tb.sv =====
module crc16_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import c16fd_pkg::*;

   // One result item as seen on the rsp_ channel
   typedef struct packed {
      status_type  status;
      logic [6:0]  frame_length;
      logic [7:0]  sequence_res;
      logic [7:0]  message_id;
      logic        has_payload;
      logic [7:0]  payload_byte;
      logic [5:0]  byte_index;
      logic        last;
   } deframe_result_type;

   // Frame decoder model plus the queue of results it still owes
   class deframe_scoreboard;
      logic [7:0]         sync_first;
      logic [7:0]         sync_second;
      logic [7:0]         tail_value;
      logic [6:0]         max_payload;
      phase_type          rx_phase;
      logic [7:0]         held_length;
      logic [7:0]         held_sequence;
      logic [7:0]         held_message_id;
      logic [7:0]         received_crc_low;
      logic [15:0]        running_crc;
      logic [6:0]         payload_count;
      bit                 crc_bad;
      logic [7:0]         payload_store [DEF_PAYLOAD_DEPTH];
      deframe_result_type expected_results [$];
      int                 errors;

      function new();
         sync_first       = 8'hAA;
         sync_second      = 8'h55;
         tail_value       = 8'h0D;
         max_payload      = 7'd64;
         rx_phase         = PH_SYNC0;
         held_length      = '0;
         held_sequence    = '0;
         held_message_id  = '0;
         received_crc_low = '0;
         running_crc      = CRC_INIT;
         payload_count    = '0;
         crc_bad          = 1'b0;
         errors           = 0;
         foreach (payload_store[i]) payload_store[i] = '0;
      endfunction

      // Fold one byte into the CCITT CRC, MSB first
      function logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         c = crc ^ {b, 8'h00};
         for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
               c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
               c = {c[14:0], 1'b0};
            end
         end
         return c;
      endfunction

      function void push_result(status_type st, logic [6:0] len, logic [7:0] seq,
                                logic [7:0] id, logic hp, logic [7:0] pb,
                                logic [5:0] idx, logic lst);
         deframe_result_type r;
         r.status       = st;
         r.frame_length = len;
         r.sequence_res = seq;
         r.message_id   = id;
         r.has_payload  = hp;
         r.payload_byte = pb;
         r.byte_index   = idx;
         r.last         = lst;
         expected_results.push_back(r);
      endfunction

      // Advance the decoder by one accepted item
      function void note_byte(logic [7:0] b);
         case (rx_phase)
            PH_SYNC0: begin
               if (b == sync_first) rx_phase = PH_SYNC1;
            end
            PH_SYNC1: begin
               if (b == sync_second) begin
                  running_crc   = CRC_INIT;
                  payload_count = '0;
                  crc_bad       = 1'b0;
                  rx_phase      = PH_LEN;
               end else if (b != sync_first) begin
                  rx_phase = PH_SYNC0;
               end
            end
            PH_LEN: begin
               held_length = b;
               if (int'(b) > int'(max_payload) || int'(b) > DEF_PAYLOAD_DEPTH) begin
                  push_result(ST_LEN_BIG, (b > 8'd127) ? LEN_SAT : b[6:0],
                              '0, '0, 1'b0, '0, '0, 1'b1);
                  rx_phase = PH_SYNC0;
               end else begin
                  running_crc = crc_fold(running_crc, b);
                  rx_phase    = PH_SEQ;
               end
            end
            PH_SEQ: begin
               held_sequence = b;
               running_crc   = crc_fold(running_crc, b);
               rx_phase      = PH_ID;
            end
            PH_ID: begin
               held_message_id = b;
               running_crc     = crc_fold(running_crc, b);
               rx_phase        = (held_length == 8'd0) ? PH_CRCLO : PH_PAY;
            end
            PH_PAY: begin
               if (int'(payload_count) < DEF_PAYLOAD_DEPTH)
                  payload_store[payload_count[5:0]] = b;
               running_crc   = crc_fold(running_crc, b);
               payload_count = payload_count + 7'd1;
               if ({1'b0, payload_count} >= held_length) rx_phase = PH_CRCLO;
            end
            PH_CRCLO: begin
               received_crc_low = b;
               rx_phase         = PH_CRCHI;
            end
            PH_CRCHI: begin
               crc_bad  = ({b, received_crc_low} != running_crc);
               rx_phase = PH_TAIL;
            end
            PH_TAIL: begin
               // Tail is judged before the CRC
               if (b != tail_value) begin
                  push_result(ST_BAD_TAIL, held_length[6:0], held_sequence,
                              held_message_id, 1'b0, '0, '0, 1'b1);
               end else if (crc_bad) begin
                  push_result(ST_BAD_CRC, held_length[6:0], held_sequence,
                              held_message_id, 1'b0, '0, '0, 1'b1);
               end else if (held_length == 8'd0) begin
                  push_result(ST_OK, '0, held_sequence, held_message_id,
                              1'b0, '0, '0, 1'b1);
               end else begin
                  for (int i = 0; i < int'(held_length) && i < DEF_PAYLOAD_DEPTH; i++)
                     push_result(ST_OK, held_length[6:0], held_sequence, held_message_id,
                                 1'b1, payload_store[i], 6'(i),
                                 (i + 1 == int'(held_length)));
               end
               rx_phase = PH_SYNC0;
            end
            default: rx_phase = PH_SYNC0;
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // Match one accepted result against the oldest one owed
      function void check_result(deframe_result_type got);
         deframe_result_type want;
         if (expected_results.size() == 0) begin
            $error("result with none owed: status %0d length %0d index %0d",
                   got.status, got.frame_length, got.byte_index);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("status", 16'(want.status), 16'(got.status));
         compare_field("frame_length", 16'(want.frame_length), 16'(got.frame_length));
         compare_field("sequence_res", 16'(want.sequence_res), 16'(got.sequence_res));
         compare_field("message_id", 16'(want.message_id), 16'(got.message_id));
         compare_field("has_payload", 16'(want.has_payload), 16'(got.has_payload));
         compare_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
         compare_field("byte_index", 16'(want.byte_index), 16'(got.byte_index));
         compare_field("last", 16'(want.last), 16'(got.last));
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [7:0]          req_rx_byte;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [1:0]          rsp_status;
   logic [LEN_W-1:0]    rsp_frame_length;
   logic [7:0]          rsp_sequence_res;
   logic [7:0]          rsp_message_id;
   logic                rsp_has_payload;
   logic [7:0]          rsp_payload_byte;
   logic [IDX_W-1:0]    rsp_byte_index;
   logic                rsp_last;
   logic                csr_we;
   logic [1:0]          csr_index;
   logic [7:0]          csr_wdata;

   deframe_scoreboard   sb;
   int                  items_sent = 0;
   int                  send_quiet = 0;

   crc16_frame_deframer uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_sequence_res (rsp_sequence_res),
      .rsp_message_id   (rsp_message_id),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_last         (rsp_last),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   // Check every accepted result item
   always @(posedge clock) begin
      deframe_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status       = status_type'(rsp_status);
         got.frame_length = rsp_frame_length;
         got.sequence_res = rsp_sequence_res;
         got.message_id   = rsp_message_id;
         got.has_payload  = rsp_has_payload;
         got.payload_byte = rsp_payload_byte;
         got.byte_index   = rsp_byte_index;
         got.last         = rsp_last;
         sb.check_result(got);
      end
   end

   // Receiver back-pressure: short stalls mostly, a few long ones, some long open stretches
   initial begin : ready_gen
      int on_len;
      int off_len;
      int r;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         r = $urandom_range(0, 99);
         on_len = (r < 6) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         rsp_ready <= 1'b1;
         repeat (on_len) @(posedge clock);
         r = $urandom_range(0, 99);
         if (r < 55) off_len = $urandom_range(1, 3);
         else if (r < 80) off_len = 0;
         else if (r < 93) off_len = $urandom_range(4, 8);
         else off_len = $urandom_range(15, 40);
         if (off_len > 0) begin
            rsp_ready <= 1'b0;
            repeat (off_len) @(posedge clock);
         end
      end
   end

   // Sender gap: mostly none or short, a few long, with quiet stretches of no gaps
   function automatic int pick_send_gap();
      int r;
      if (send_quiet > 0) begin
         send_quiet--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         send_quiet = $urandom_range(15, 50);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one item and hold it until taken
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = pick_send_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b);
      items_sent++;
   endtask

   // Drop valid and let every owed result drain, then settle
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] tail, input logic [6:0] maxp);
      csr_we    <= 1'b1;
      csr_index <= REG_SYNC_FIRST;
      csr_wdata <= s1;
      @(posedge clock);
      csr_index <= REG_SYNC_SECOND;
      csr_wdata <= s2;
      @(posedge clock);
      csr_index <= REG_TAIL_VALUE;
      csr_wdata <= tail;
      @(posedge clock);
      csr_index <= REG_MAX_PAYLOAD;
      csr_wdata <= {1'b0, maxp};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      sb.sync_first  = s1;
      sb.sync_second = s2;
      sb.tail_value  = tail;
      sb.max_payload = maxp;
   endtask

   // Build and send one frame; flip masks corrupt the CRC or the tail
   task automatic send_frame(input int len, input logic [15:0] crc_flip,
                             input logic [7:0] tail_flip);
      logic [7:0]  seq;
      logic [7:0]  id;
      logic [7:0]  pay;
      logic [15:0] crc;
      seq = 8'($urandom);
      id  = 8'($urandom);
      crc = CRC_INIT;
      send_byte(sb.sync_first);
      send_byte(sb.sync_second);
      crc = sb.crc_fold(crc, 8'(len));
      send_byte(8'(len));
      crc = sb.crc_fold(crc, seq);
      send_byte(seq);
      crc = sb.crc_fold(crc, id);
      send_byte(id);
      for (int i = 0; i < len; i++) begin
         pay = 8'($urandom);
         crc = sb.crc_fold(crc, pay);
         send_byte(pay);
      end
      crc = crc ^ crc_flip;
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      send_byte(sb.tail_value ^ tail_flip);
   endtask

   // Feed bytes that match no sync value until the decoder is hunting again
   task automatic flush_to_hunt();
      logic [7:0] b;
      while (sb.rx_phase != PH_SYNC0) begin
         do b = 8'($urandom); while (b == sb.sync_first || b == sb.sync_second);
         send_byte(b);
      end
   endtask

   // Mostly good frames, the rest corrupt frames, noise and broken sync
   task automatic run_random(input int budget);
      int         start;
      int         kind;
      int         len;
      int         maxp;
      logic [7:0] b;
      start = items_sent;
      while (items_sent - start < budget) begin
         maxp = int'(sb.max_payload);
         kind = $urandom_range(0, 99);
         if (kind < 75) len = $urandom_range(0, (maxp < 6) ? maxp : 6);
         else if (kind < 92) len = $urandom_range(0, maxp);
         else len = maxp;
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            send_frame(len, 16'h0000, 8'h00);
         end else if (kind < 68) begin
            send_frame(len, 16'($urandom_range(1, 16'hFFFF)), 8'h00);
         end else if (kind < 75) begin
            send_frame(len, 16'h0000, 8'($urandom_range(1, 255)));
         end else if (kind < 82) begin
            // Oversize length, then leftovers that must not resync
            send_byte(sb.sync_first);
            send_byte(sb.sync_second);
            send_byte(8'($urandom_range(maxp + 1, 255)));
            repeat ($urandom_range(0, 4)) send_byte(8'($urandom));
         end else if (kind < 90) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
         end else begin
            // Repeated first sync byte, then a break
            send_byte(sb.sync_first);
            repeat ($urandom_range(0, 2)) send_byte(sb.sync_first);
            do b = 8'($urandom); while (b == sb.sync_first || b == sb.sync_second);
            send_byte(b);
         end
         if ($urandom_range(0, 19) == 0) wait_drained();
      end
   endtask

   // Main sequence
   initial begin
      sb = new();
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_rx_byte <= '0;
      csr_we      <= 1'b0;
      csr_index   <= REG_SYNC_FIRST;
      csr_wdata   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: broken sync, resync on repeated first byte with empty frame,
      // saturated oversize length, bad tail hiding a bad CRC
      send_byte(sb.sync_first);
      send_byte(8'h12);
      send_byte(sb.sync_first);
      send_frame(0, 16'h0000, 8'h00);
      send_byte(sb.sync_first);
      send_byte(sb.sync_second);
      send_byte(8'hFF);
      send_frame(1, 16'h0001, 8'hFF);
      run_random(20);
      flush_to_hunt();
      wait_drained();

      // Low extremes: zero max payload
      write_config(8'h00, 8'hFF, 8'hFF, 7'd0);
      run_random(15);
      flush_to_hunt();
      wait_drained();

      // High extremes: one full-depth frame first
      write_config(8'hFF, 8'h00, 8'h00, 7'd64);
      send_frame(64, 16'h0000, 8'h00);
      run_random(5);
      flush_to_hunt();
      wait_drained();

      // Random settings
      write_config(8'($urandom), 8'($urandom), 8'($urandom), 7'($urandom_range(1, 20)));
      run_random(15);
      flush_to_hunt();
      wait_drained();

      // Both sync bytes equal
      write_config(8'h5A, 8'h5A, 8'($urandom), 7'd64);
      run_random(15);
      flush_to_hunt();
      wait_drained();

      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/c16fd_pkg.sv
sv/crc16_frame_deframer.sv
verif/crc16_frame_deframer_tb.sv
